// File: rtl/neighbourhood_mean_smoother_unit_assert.svh
// Assertion macros used by the port checker of the smoother unit.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge.
`ifndef NEIGHBOURHOOD_MEAN_SMOOTHER_UNIT_ASSERT_SVH
`define NEIGHBOURHOOD_MEAN_SMOOTHER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NMSU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NMSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/nmsu_pkg.sv
// Shared types and constants of the neighbourhood mean smoother.
// No dependencies; used by the front end, back end, top level, port checker and testbench.
`default_nettype none

package nmsu_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = SAMPLE_W + 4;
  localparam int IDX_W       = 10;
  localparam int CFG_W       = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int CNT_W       = 4;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'b1;
  localparam logic [CFG_W-1:0]     FRAME_DIM_RESET = 11'd3;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smoothed;
    logic [IDX_W-1:0]           out_row;
    logic [IDX_W-1:0]           out_col;
    logic                       frame_done;
  } out_item_t;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    logic             kind;
    logic             emit_a;
    logic             emit_b;
    logic             r_ge2;
    logic             c_ge1;
    logic             c_ge2;
    logic             two_rows;
    logic             done;
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
  } op_ctl_t;

endpackage

`default_nettype wire

// File: rtl/nmsu_fifo.sv
// Small register-based first-in first-out queue used between the stages.
// No package dependency; width and depth come from its parameters.
`default_nettype none

module nmsu_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// File: rtl/nmsu_front.sv
// Front end: geometry registers, raster position tracking and request classification.
// Depends on nmsu_pkg for the item and request types.
`default_nettype none

module nmsu_front #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024,
  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  nmsu_pkg::in_item_t             in_data,
  input  logic                           op_full,
  input  logic                           cfg_we,
  input  logic [nmsu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nmsu_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                           op_push,
  output nmsu_pkg::op_ctl_t              op_ctl,
  output logic [nmsu_pkg::SAMPLE_W-1:0]  op_sample,
  output logic [AW-1:0]                  op_addr,
  output logic [AW-1:0]                  op_hi
);

  import nmsu_pkg::*;

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int LR  = $clog2(MAX_ROWS + 1);
  localparam int LC  = $clog2(MAX_COLS + 1);
  localparam int LW0 = (LR > LC) ? LR : LC;
  localparam int XW  = ((LW0 > CFG_W) ? LW0 : CFG_W) + 1;

  logic [CFG_W-1:0] frame_rows_r, frame_cols_r;
  logic [RW-1:0]    in_row_r, in_row_nxt;
  logic [AW-1:0]    in_col_r, in_col_nxt;
  logic [AW-1:0]    flush_col_r, flush_col_nxt;
  logic             frame_full_r, frame_full_nxt;
  logic [XW-1:0]    rows_lim, cols_lim, row_x, col_x, fc_x;
  logic             last_col, last_row, flush_last, accept;

  // Out-of-range geometry: zero acts as one, oversize acts as the maximum.
  always_comb begin
    if (frame_rows_r == '0) begin
      rows_lim = XW'(1);
    end else if (XW'(frame_rows_r) > XW'(MAX_ROWS)) begin
      rows_lim = XW'(MAX_ROWS);
    end else begin
      rows_lim = XW'(frame_rows_r);
    end
    if (frame_cols_r == '0) begin
      cols_lim = XW'(1);
    end else if (XW'(frame_cols_r) > XW'(MAX_COLS)) begin
      cols_lim = XW'(MAX_COLS);
    end else begin
      cols_lim = XW'(frame_cols_r);
    end
  end

  assign row_x      = XW'(in_row_r);
  assign col_x      = XW'(in_col_r);
  assign fc_x       = XW'(flush_col_r);
  assign last_row   = (row_x + XW'(1)) >= rows_lim;
  assign last_col   = (col_x + XW'(1)) >= cols_lim;
  assign flush_last = (fc_x + XW'(1)) >= cols_lim;
  assign accept     = push && !op_full;

  always_comb begin
    in_row_nxt     = in_row_r;
    in_col_nxt     = in_col_r;
    flush_col_nxt  = flush_col_r;
    frame_full_nxt = frame_full_r;
    op_push        = 1'b0;
    op_ctl         = '0;
    op_sample      = in_data.sample;
    op_addr        = in_col_r;
    op_hi          = in_col_r;
    if (accept) begin
      if (in_data.kind == KIND_FLUSH) begin
        // A flush releases one last-row result; without a complete frame it is dropped.
        if (frame_full_r) begin
          op_push         = 1'b1;
          op_ctl.kind     = KIND_FLUSH;
          op_ctl.two_rows = rows_lim >= XW'(2);
          op_ctl.done     = flush_last;
          op_ctl.out_row  = IDX_W'(rows_lim - XW'(1));
          op_ctl.out_col  = IDX_W'(fc_x);
          op_addr         = (flush_col_r != '0) ? flush_col_r - 1'b1 : flush_col_r;
          op_hi           = flush_last ? flush_col_r : flush_col_r + 1'b1;
          if (flush_last) begin
            frame_full_nxt = 1'b0;
            flush_col_nxt  = '0;
            in_row_nxt     = '0;
            in_col_nxt     = '0;
          end else begin
            flush_col_nxt = flush_col_r + 1'b1;
          end
        end
      end else if (!frame_full_r) begin
        op_push        = 1'b1;
        op_ctl.kind    = KIND_PIXEL;
        op_ctl.emit_a  = (in_row_r != '0) && (in_col_r != '0);
        op_ctl.emit_b  = (in_row_r != '0) && last_col;
        op_ctl.r_ge2   = row_x >= XW'(2);
        op_ctl.c_ge1   = in_col_r != '0;
        op_ctl.c_ge2   = col_x >= XW'(2);
        op_ctl.out_row = IDX_W'(row_x - XW'(1));
        op_ctl.out_col = IDX_W'(col_x);
        if (last_col) begin
          in_col_nxt = '0;
          if (last_row) begin
            frame_full_nxt = 1'b1;
            flush_col_nxt  = '0;
          end else begin
            in_row_nxt = in_row_r + 1'b1;
          end
        end else begin
          in_col_nxt = in_col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rows_r <= FRAME_DIM_RESET;
      frame_cols_r <= FRAME_DIM_RESET;
      in_row_r     <= '0;
      in_col_r     <= '0;
      flush_col_r  <= '0;
      frame_full_r <= 1'b0;
    end else begin
      in_row_r     <= in_row_nxt;
      in_col_r     <= in_col_nxt;
      flush_col_r  <= flush_col_nxt;
      frame_full_r <= frame_full_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_ROWS: frame_rows_r <= cfg_wdata;
          REG_FRAME_COLS: frame_cols_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/nmsu_back.sv
// Back end: line buffers, 3x3 window, neighbourhood sums and mean by reciprocal multiply.
// Depends on nmsu_pkg for the request and result types.
`default_nettype none

module nmsu_back #(
  parameter int MAX_COLS = 1024,
  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          op_empty,
  output logic                          op_pop,
  input  nmsu_pkg::op_ctl_t             op_ctl_in,
  input  logic [nmsu_pkg::SAMPLE_W-1:0] op_sample_in,
  input  logic [AW-1:0]                 op_addr_in,
  input  logic [AW-1:0]                 op_hi_in,
  input  logic                          res_full,
  output logic                          res_push,
  output nmsu_pkg::out_item_t           res_item
);

  import nmsu_pkg::*;

  localparam int PRW = SUM_W + RECIP_W;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_PIX  = 3'd1;
  localparam logic [2:0] B_FACC = 3'd2;
  localparam logic [2:0] B_MUL  = 3'd3;
  localparam logic [2:0] B_PUSH = 3'd4;

  // Reciprocal ceil(2^24 / n): exact floor division for every reachable sum magnitude.
  function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] r;
    case (cnt)
      4'd1:    r = 25'd16777216;
      4'd2:    r = 25'd8388608;
      4'd3:    r = 25'd5592406;
      4'd4:    r = 25'd4194304;
      4'd5:    r = 25'd3355444;
      4'd6:    r = 25'd2796203;
      4'd7:    r = 25'd2396746;
      4'd8:    r = 25'd2097152;
      4'd9:    r = 25'd1864136;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [SUM_W-1:0] sx(input logic [SAMPLE_W-1:0] v);
    return {{(SUM_W - SAMPLE_W){v[SAMPLE_W-1]}}, v};
  endfunction

  logic [2:0]          state_r, state_nxt;
  op_ctl_t             cur_ctl_r;
  logic [SAMPLE_W-1:0] cur_sample_r;
  logic [AW-1:0]       cur_addr_r, cur_hi_r, fcur_r, rd_addr;

  logic [SAMPLE_W-1:0] older_mem [MAX_COLS];
  logic [SAMPLE_W-1:0] newer_mem [MAX_COLS];
  logic [SAMPLE_W-1:0] older_q_r, newer_q_r;

  logic [SAMPLE_W-1:0] win_r [3][3];
  logic [SAMPLE_W-1:0] nw [3][3];
  logic [SUM_W-1:0]    cs [3];
  logic [SUM_W-1:0]    sum_a, sum_b;
  logic [CNT_W-1:0]    cnt_a, cnt_b;

  logic [SUM_W-1:0]    acc_r, acc_nxt;
  logic [CNT_W-1:0]    acc_cnt_r, acc_cnt_nxt;

  logic [SUM_W-1:0]    slot_sum_r [2];
  logic [CNT_W-1:0]    slot_cnt_r [2];
  logic [IDX_W-1:0]    slot_col_r [2];
  logic                slot_done_r [2];
  logic [1:0]          slot_v_r;
  logic                sel, sel_r;

  logic [SUM_W-1:0]    mag, quot, mean;
  logic [PRW-1:0]      prod_r;
  logic                neg_r;

  assign op_pop  = (state_r == B_IDLE) && !op_empty;
  assign rd_addr = (state_r == B_FACC) ? fcur_r + 1'b1 : op_addr_in;

  // Window after shifting in the new column of a pixel request.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nw[k][0] = win_r[k][1];
      nw[k][1] = win_r[k][2];
    end
    nw[0][2] = older_q_r;
    nw[1][2] = newer_q_r;
    nw[2][2] = cur_sample_r;
    for (int j = 0; j < 3; j++) begin
      cs[j] = (cur_ctl_r.r_ge2 ? sx(nw[0][j]) : '0) + sx(nw[1][j]) + sx(nw[2][j]);
    end
    sum_a = (cur_ctl_r.c_ge2 ? cs[0] : '0) + cs[1] + cs[2];
    sum_b = (cur_ctl_r.c_ge1 ? cs[1] : '0) + cs[2];
    if (cur_ctl_r.r_ge2) begin
      cnt_a = cur_ctl_r.c_ge2 ? CNT_W'(9) : CNT_W'(6);
      cnt_b = cur_ctl_r.c_ge1 ? CNT_W'(6) : CNT_W'(3);
    end else begin
      cnt_a = cur_ctl_r.c_ge2 ? CNT_W'(6) : CNT_W'(4);
      cnt_b = cur_ctl_r.c_ge1 ? CNT_W'(4) : CNT_W'(2);
    end
  end

  always_comb begin
    acc_nxt     = acc_r + sx(newer_q_r) + (cur_ctl_r.two_rows ? sx(older_q_r) : '0);
    acc_cnt_nxt = acc_cnt_r + (cur_ctl_r.two_rows ? CNT_W'(2) : CNT_W'(1));
  end

  assign sel  = slot_v_r[0] ? 1'b0 : 1'b1;
  assign mag  = slot_sum_r[sel][SUM_W-1] ? (~slot_sum_r[sel] + 1'b1) : slot_sum_r[sel];
  assign quot = prod_r[RECIP_SHIFT +: SUM_W];
  assign mean = neg_r ? (~quot + 1'b1) : quot;

  always_comb begin
    res_push            = (state_r == B_PUSH) && !res_full;
    res_item.smoothed   = mean[SAMPLE_W-1:0];
    res_item.out_row    = cur_ctl_r.out_row;
    res_item.out_col    = slot_col_r[sel_r];
    res_item.frame_done = slot_done_r[sel_r];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!op_empty) begin
          state_nxt = (op_ctl_in.kind == KIND_FLUSH) ? B_FACC : B_PIX;
        end
      end
      B_PIX:  state_nxt = (cur_ctl_r.emit_a || cur_ctl_r.emit_b) ? B_MUL : B_IDLE;
      B_FACC: state_nxt = (fcur_r == cur_hi_r) ? B_MUL : B_FACC;
      B_MUL:  state_nxt = B_PUSH;
      B_PUSH: begin
        if (!res_full) begin
          state_nxt = (!sel_r && slot_v_r[1]) ? B_MUL : B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Control state and the window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      slot_v_r <= '0;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[k][j] <= '0;
        end
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        B_PIX: begin
          win_r    <= nw;
          slot_v_r <= {cur_ctl_r.emit_b, cur_ctl_r.emit_a};
        end
        B_FACC: begin
          if (fcur_r == cur_hi_r) begin
            slot_v_r[0] <= 1'b1;
          end
        end
        B_PUSH: begin
          if (!res_full) begin
            slot_v_r[sel_r] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (!op_empty) begin
          cur_ctl_r    <= op_ctl_in;
          cur_sample_r <= op_sample_in;
          cur_addr_r   <= op_addr_in;
          cur_hi_r     <= op_hi_in;
          fcur_r       <= op_addr_in;
          acc_r        <= '0;
          acc_cnt_r    <= '0;
        end
      end
      B_PIX: begin
        slot_sum_r[0]  <= sum_a;
        slot_cnt_r[0]  <= cnt_a;
        slot_col_r[0]  <= cur_ctl_r.out_col - 1'b1;
        slot_done_r[0] <= 1'b0;
        slot_sum_r[1]  <= sum_b;
        slot_cnt_r[1]  <= cnt_b;
        slot_col_r[1]  <= cur_ctl_r.out_col;
        slot_done_r[1] <= 1'b0;
      end
      B_FACC: begin
        acc_r     <= acc_nxt;
        acc_cnt_r <= acc_cnt_nxt;
        fcur_r    <= fcur_r + 1'b1;
        if (fcur_r == cur_hi_r) begin
          slot_sum_r[0]  <= acc_nxt;
          slot_cnt_r[0]  <= acc_cnt_nxt;
          slot_col_r[0]  <= cur_ctl_r.out_col;
          slot_done_r[0] <= cur_ctl_r.done;
        end
      end
      B_MUL: begin
        prod_r <= PRW'(mag) * PRW'(recip_of(slot_cnt_r[sel]));
        neg_r  <= slot_sum_r[sel][SUM_W-1];
        sel_r  <= sel;
      end
      default: ;
    endcase
  end

  // Line buffers: one registered read per cycle each, and one write each in the pixel state.
  always_ff @(posedge clk) begin
    if (state_r == B_PIX) begin
      older_mem[cur_addr_r] <= newer_q_r;
      newer_mem[cur_addr_r] <= cur_sample_r;
    end
    older_q_r <= older_mem[rd_addr];
    newer_q_r <= newer_mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/neighbourhood_mean_smoother_unit.sv
// Top level of the 3x3 neighbourhood mean smoother: front end, request queue, back end,
// result queue. Depends on nmsu_pkg, nmsu_fifo, nmsu_front and nmsu_back.
//
//   Channel  Dir  Handshake                  Payload
//   input    in   push / full                in_data   (kind, sample)
//   result   out  pop / empty                out_data  (smoothed, out_row, out_col, frame_done)
//   config   in   cfg_we (no wait)           cfg_index, cfg_wdata (frame_rows, frame_cols)
//
// The back end runs one request at a time: a pixel releases up to two results, each through
// a multiply and a push, and a flush reads one line-buffer column per cycle through the
// single read port of each buffer before the multiply and the push.
// A four-entry request queue and a four-entry result queue let input and output stall
// independently. Reset (synchronous, active low) empties both queues and clears position
// state and the window; line buffers are not cleared.
`default_nettype none

module neighbourhood_mean_smoother_unit #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  nmsu_pkg::in_item_t             in_data,
  output logic                           empty,
  input  logic                           pop,
  output nmsu_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [nmsu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nmsu_pkg::CFG_W-1:0]     cfg_wdata
);

  import nmsu_pkg::*;

  localparam int AW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int OPW   = $bits(op_ctl_t) + SAMPLE_W + 2 * AW;
  localparam int RESW  = $bits(out_item_t);
  localparam int QDEPTH = 4;

  logic                op_push, op_full, op_empty, op_pop;
  op_ctl_t             op_ctl, op_ctl_q;
  logic [SAMPLE_W-1:0] op_sample, op_sample_q;
  logic [AW-1:0]       op_addr, op_addr_q, op_hi, op_hi_q;
  logic [OPW-1:0]      op_wdata, op_rdata;
  logic                res_push, res_full;
  out_item_t           res_item;

  assign full     = op_full;
  assign op_wdata = {op_ctl, op_sample, op_addr, op_hi};
  assign {op_ctl_q, op_sample_q, op_addr_q, op_hi_q} = op_rdata;

  nmsu_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_data   (in_data),
    .op_full   (op_full),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .op_push   (op_push),
    .op_ctl    (op_ctl),
    .op_sample (op_sample),
    .op_addr   (op_addr),
    .op_hi     (op_hi)
  );

  nmsu_fifo #(
    .W     (OPW),
    .DEPTH (QDEPTH)
  ) u_op_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (op_push),
    .wdata (op_wdata),
    .pop   (op_pop),
    .rdata (op_rdata),
    .full  (op_full),
    .empty (op_empty)
  );

  nmsu_back #(
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .op_empty     (op_empty),
    .op_pop       (op_pop),
    .op_ctl_in    (op_ctl_q),
    .op_sample_in (op_sample_q),
    .op_addr_in   (op_addr_q),
    .op_hi_in     (op_hi_q),
    .res_full     (res_full),
    .res_push     (res_push),
    .res_item     (res_item)
  );

  nmsu_fifo #(
    .W     (RESW),
    .DEPTH (QDEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_item),
    .pop   (pop),
    .rdata (out_data),
    .full  (res_full),
    .empty (empty)
  );

endmodule

`default_nettype wire

// File: rtl/nmsu_port_checker.sv
// Port-level checker for the smoother unit, attached to the top level by a bind.
// Depends on nmsu_pkg and the assertion macros in the shared header.
`default_nettype none
`include "neighbourhood_mean_smoother_unit_assert.svh"

module nmsu_port_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input nmsu_pkg::out_item_t out_data
);

  // Both queues come out of reset drained.
  `NMSU_ASSERT_SAME(a_reset_drained, clk, rst_n, !$past(rst_n), empty && !full, "queues not drained after reset")

  // The request queue fills only from an input request.
  `NMSU_ASSERT_SAME(a_full_needs_push, clk, rst_n, $rose(full), $past(push), "full rose without a push")

  // A waiting result stays put until it is popped.
  `NMSU_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop, !empty && $stable(out_data), "result changed while stalled")

endmodule

bind neighbourhood_mean_smoother_unit nmsu_port_checker u_port_checker (.*);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for neighbourhood_mean_smoother_unit: directed and random frames,
// with every result predicted here and compared in order. Needs nmsu_pkg and the RTL top.
module tb;
  import nmsu_pkg::*;

  localparam int LINE_LEN = 1024;
  localparam int ROW_LIMIT = 1024;
  localparam int RANDOM_REQUESTS = 820;
  // The back end takes one request at a time and four can wait in the queue.
  localparam int SETTLE_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  in_item_t in_data = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Shadow copy of the smoother state.
  logic [CFG_W-1:0] rows_reg = FRAME_DIM_RESET;
  logic [CFG_W-1:0] cols_reg = FRAME_DIM_RESET;
  logic signed [SAMPLE_W-1:0] line_old [LINE_LEN];
  logic signed [SAMPLE_W-1:0] line_new [LINE_LEN];
  logic signed [SAMPLE_W-1:0] win [3][3];
  logic [IDX_W-1:0] pos_row = '0;
  logic [IDX_W-1:0] pos_col = '0;
  logic [CFG_W-1:0] flush_pos = '0;
  logic frame_ready = 1'b0;

  in_item_t request_q[$];
  out_item_t predicted_results[$];
  out_item_t oldest;
  int fail_count = 0;
  int results_seen = 0;
  int random_requests = 0;
  bit req_taken = 1'b0;
  int burst_left = 1;
  int gap_left = 0;
  int hold_left = 0;
  int next_hold_at = 40;
  int mode_left = 0;
  int pop_mode = 0;

  neighbourhood_mean_smoother_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic int dim_in_use(input logic [CFG_W-1:0] v, input int lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return int'(v);
  endfunction

  function automatic int window_average(input int r0, input int c0);
    int sum, cnt, r, c;
    sum = 0;
    cnt = 0;
    for (r = r0; r < 3; r++) begin
      for (c = c0; c < 3; c++) begin
        sum += win[r][c];
        cnt++;
      end
    end
    return sum / cnt;
  endfunction

  task automatic add_result(input int value, input int row, input int col, input bit done);
    out_item_t res;
    res.smoothed = value[SAMPLE_W-1:0];
    res.out_row = row[IDX_W-1:0];
    res.out_col = col[IDX_W-1:0];
    res.frame_done = done;
    predicted_results.push_back(res);
  endtask

  task automatic predict_smoothed(input in_item_t req);
    int rows, cols, r, c, lo, hi, sum, cnt, r0, k;
    rows = dim_in_use(rows_reg, ROW_LIMIT);
    cols = dim_in_use(cols_reg, LINE_LEN);
    if (req.kind == KIND_FLUSH) begin
      // A flush releases one column of the last row, using only the rows the frame has.
      if (frame_ready) begin
        c = flush_pos;
        lo = (c >= 1) ? c - 1 : c;
        hi = (c + 1 < cols) ? c + 1 : c;
        sum = 0;
        cnt = 0;
        for (k = lo; k <= hi; k++) begin
          if (rows >= 2) begin
            sum += line_old[k];
            cnt++;
          end
          sum += line_new[k];
          cnt++;
        end
        add_result(sum / cnt, rows - 1, c, c + 1 >= cols);
        if (c + 1 >= cols) begin
          frame_ready = 1'b0;
          flush_pos = '0;
          pos_row = '0;
          pos_col = '0;
        end else begin
          flush_pos = CFG_W'(c + 1);
        end
      end
    end else if (!frame_ready) begin
      r = pos_row;
      c = pos_col;
      for (k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = line_old[c];
      win[1][2] = line_new[c];
      win[2][2] = req.sample;
      line_old[c] = line_new[c];
      line_new[c] = req.sample;
      if (r >= 1) begin
        r0 = (r >= 2) ? 0 : 1;
        if (c >= 1) add_result(window_average(r0, (c >= 2) ? 0 : 1), r - 1, c - 1, 1'b0);
        if (c + 1 >= cols) add_result(window_average(r0, (c >= 1) ? 1 : 2), r - 1, c, 1'b0);
      end
      if (c + 1 >= cols) begin
        pos_col = '0;
        if (r + 1 >= rows) begin
          frame_ready = 1'b1;
          flush_pos = '0;
        end else begin
          pos_row = IDX_W'(r + 1);
        end
      end else begin
        pos_col = IDX_W'(c + 1);
      end
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic int pick_dim(input int top_a, input int top_b, input int top_c);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) return $urandom_range(1, top_a);
    if (sel < 19) return $urandom_range(top_a + 1, top_b);
    return $urandom_range(top_b + 1, top_c);
  endfunction

  task automatic queue_request(input logic kind, input logic signed [SAMPLE_W-1:0] sample);
    in_item_t req;
    req.kind = kind;
    req.sample = sample;
    request_q.push_back(req);
  endtask

  // One complete frame and its flushes, with the odd ignored request mixed in.
  task automatic queue_frame(input int rows, input int cols);
    int n;
    for (n = 0; n < rows * cols; n++) begin
      if ($urandom_range(0, 19) == 0) queue_request(KIND_FLUSH, pick_sample());
      queue_request(KIND_PIXEL, pick_sample());
    end
    for (n = 0; n < cols; n++) begin
      if ($urandom_range(0, 19) == 0) queue_request(KIND_PIXEL, pick_sample());
      queue_request(KIND_FLUSH, pick_sample());
    end
    random_requests += rows * cols + cols;
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || push || predicted_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == REG_FRAME_ROWS) rows_reg = value;
    else cols_reg = value;
  endtask

  task automatic set_geometry(input logic [CFG_W-1:0] rows_val,
                              input logic [CFG_W-1:0] cols_val);
    wait_idle();
    write_reg(REG_FRAME_ROWS, rows_val);
    write_reg(REG_FRAME_COLS, cols_val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    if (rst_n && (!push || req_taken)) begin
      if (gap_left != 0) begin
        push <= 1'b0;
        gap_left--;
      end else if (request_q.size() != 0) begin
        push <= 1'b1;
        in_data <= request_q.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: a changing pop pattern, plus a long hold now and then to back up the input.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (results_seen >= next_hold_at) begin
        pop <= 1'b0;
        hold_left = 200;
        next_hold_at = next_hold_at + 900;
      end else begin
        if (mode_left == 0) begin
          pop_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end else begin
          mode_left--;
        end
        case (pop_mode)
          0: pop <= 1'b1;
          1: pop <= ($urandom_range(0, 1) == 0);
          2: pop <= ($urandom_range(0, 7) != 0);
          default: pop <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Monitor: predicts each accepted request and checks each accepted result.
  always @(posedge clk) begin
    if (rst_n) begin
      req_taken = push && !full;
      if (req_taken) predict_smoothed(in_data);
      if (pop && !empty) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          fail_count++;
          $display("%0t ns: unexpected result, value %0d row %0d col %0d done %0b",
                   $time, out_data.smoothed, out_data.out_row, out_data.out_col,
                   out_data.frame_done);
        end else begin
          oldest = predicted_results.pop_front();
          if (out_data.smoothed !== oldest.smoothed || out_data.out_row !== oldest.out_row ||
              out_data.out_col !== oldest.out_col ||
              out_data.frame_done !== oldest.frame_done) begin
            fail_count++;
            $display("%0t ns: mismatch, expected %0d r%0d c%0d d%0b, got %0d r%0d c%0d d%0b",
                     $time, oldest.smoothed, oldest.out_row, oldest.out_col,
                     oldest.frame_done, out_data.smoothed, out_data.out_row,
                     out_data.out_col, out_data.frame_done);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int rows, cols, frames, j, k;
    for (j = 0; j < 3; j++) begin
      for (k = 0; k < 3; k++) win[j][k] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset geometry is 3x3. A flush before any frame is ignored.
    queue_request(KIND_FLUSH, 16'sh7FFF);
    queue_request(KIND_PIXEL, 16'sh7FFF);
    queue_request(KIND_PIXEL, 16'sh8000);
    queue_request(KIND_PIXEL, 16'sh8000);
    queue_request(KIND_PIXEL, 16'sh8000);
    queue_request(KIND_PIXEL, 16'sh7FFF);
    queue_request(KIND_PIXEL, 16'sh8000);
    queue_request(KIND_PIXEL, -16'sd1);
    queue_request(KIND_PIXEL, 16'sd1);
    queue_request(KIND_PIXEL, 16'sh8000);
    // The frame is complete, so this pixel is dropped; pixels are ignored until the last flush.
    queue_request(KIND_PIXEL, 16'sh1234);
    queue_request(KIND_FLUSH, '0);
    queue_request(KIND_FLUSH, '1);
    queue_request(KIND_FLUSH, 16'sh5555);

    // Zero in both registers acts as a one-pixel frame.
    set_geometry('0, '0);
    queue_request(KIND_PIXEL, 16'sh8000);
    queue_request(KIND_FLUSH, '0);

    // A single column: each pixel after the first row gives only the row-end result.
    set_geometry(11'd2, 11'd1);
    queue_request(KIND_PIXEL, 16'sh8000);
    queue_request(KIND_PIXEL, -16'sd1);
    queue_request(KIND_FLUSH, '0);

    // Tallest frame: an oversize row count acts as the maximum and zero columns as one.
    set_geometry(11'd2047, '0);
    queue_frame(1024, 1);

    random_requests = 0;
    while (random_requests < RANDOM_REQUESTS) begin
      rows = pick_dim(6, 16, 32);
      cols = pick_dim(8, 24, 64);
      set_geometry((rows == 1 && $urandom_range(0, 1) == 0) ? 11'd0 : rows[CFG_W-1:0],
                   (cols == 1 && $urandom_range(0, 1) == 0) ? 11'd0 : cols[CFG_W-1:0]);
      frames = $urandom_range(1, 3);
      repeat (frames) queue_frame(rows, cols);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
